@@ design/abrq_pkg.sv @@
`default_nettype none
package abrq_pkg;

	localparam int MAX_RAYS     = 256;
	localparam int RAY_CAPACITY = 512;
	localparam int RAY_W        = $clog2(MAX_RAYS);
	localparam int FILL_W       = $clog2(RAY_CAPACITY + 1);
	localparam int CNT_W        = $clog2(MAX_RAYS + 1);
	localparam int STEP_W       = $clog2(RAY_W);
	localparam int ANGLE_W      = 16;
	localparam int NRAYS_W      = 9;
	localparam int MINPTS_W     = 10;
	localparam int CMP_W        = (FILL_W > MINPTS_W) ? FILL_W : MINPTS_W;
	localparam int FIFO_DEPTH   = 2;
	localparam int FIFO_AW      = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW      = $clog2(FIFO_DEPTH + 1);

	typedef enum logic [2:0] {
		REG_START_ANG = 3'd0,
		REG_RAY_WIDTH = 3'd1,
		REG_NUM_RAYS  = 3'd2,
		REG_MIN_PTS   = 3'd3,
		REG_WRAP      = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ACT_INSERT = 2'd0,
		ACT_EOS    = 2'd1,
		ACT_POP    = 2'd2,
		ACT_CLEAR  = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_OK     = 3'd0,
		ST_MARKER = 3'd1,
		ST_FULL   = 3'd2,
		ST_RANGE  = 3'd3,
		ST_NONE   = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		MODE_NOT_READY = 2'd0,
		MODE_READY     = 2'd1,
		MODE_RESET     = 2'd2
	} ray_mode_t;

	typedef enum logic [2:0] {
		CMD_INSERT,
		CMD_MARKER,
		CMD_RANGE,
		CMD_EOS,
		CMD_POP,
		CMD_CLEAR
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t        kind;
		logic [RAY_W-1:0] bin;
	} cmd_t;

	typedef struct packed {
		logic signed [ANGLE_W-1:0] start_ang;
		logic [ANGLE_W-1:0]        ray_width;
		logic [CNT_W-1:0]          n_act;
		logic [MINPTS_W-1:0]       min_pts;
		logic                      wrap;
	} cfg_t;

	typedef struct packed {
		status_t           status;
		logic [RAY_W-1:0]  ray_index;
		logic [FILL_W-1:0] ray_points;
		logic [CNT_W-1:0]  ready_count;
	} res_t;

	typedef struct packed {
		ray_mode_t         mode;
		logic [FILL_W-1:0] fill;
	} ray_ent_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_DIV,
		F_PUSH
	} front_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_NORM,
		B_INS,
		B_EOS,
		B_TAKE,
		B_TAKE_WR,
		B_OUT
	} back_state_t;

endpackage
`default_nettype wire

@@ design/abrq_front.sv @@
`default_nettype none
module abrq_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire abrq_pkg::cfg_t                cfg,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [1:0]                    action,
	input  wire logic [abrq_pkg::ANGLE_W-1:0]  point_angle,
	input  wire logic                          is_end_marker,
	output logic                               push,
	output abrq_pkg::cmd_t                     push_cmd,
	input  wire logic                          fifo_full
);
	localparam int RW = abrq_pkg::RAY_W;
	localparam int AW = abrq_pkg::ANGLE_W;
	localparam int SW = abrq_pkg::STEP_W;

	abrq_pkg::front_state_t state_q, state_d;
	abrq_pkg::cmd_kind_t    kind_q, kind_d;
	logic [AW-1:0]          rem_q, rem_d;
	logic [RW-1:0]          quot_q, quot_d;
	logic [SW-1:0]          k_q, k_d;

	logic signed [AW:0]     diff;
	logic                   d_pos;
	logic [AW-1:0]          w_eff;
	logic                   too_big;
	logic [AW+RW-1:0]       shifted;
	logic                   ge;
	logic                   accept;

	// angle offset from the field start, folded once when the field wraps
	assign diff    = {point_angle[AW-1], point_angle} - {cfg.start_ang[AW-1], cfg.start_ang};
	assign d_pos   = (cfg.wrap || !diff[AW]) && (diff[AW-1:0] != '0);
	assign w_eff   = (cfg.ray_width == '0) ? AW'(1) : cfg.ray_width;
	assign too_big = {{RW{1'b0}}, diff[AW-1:0]} >= {w_eff, {RW{1'b0}}};
	assign shifted = {{RW{1'b0}}, w_eff} << k_q;
	assign ge      = {{RW{1'b0}}, rem_q} >= shifted;
	assign accept  = in_valid && in_ready;

	always_comb begin
		state_d  = state_q;
		kind_d   = kind_q;
		rem_d    = rem_q;
		quot_d   = quot_q;
		k_d      = k_q;
		in_ready = 1'b0;
		push     = 1'b0;
		push_cmd = '{kind: kind_q, bin: quot_q};
		case (state_q)
			abrq_pkg::F_IDLE: begin
				in_ready = 1'b1;
				if (accept) begin
					quot_d  = '0;
					rem_d   = diff[AW-1:0];
					k_d     = SW'(RW - 1);
					state_d = abrq_pkg::F_PUSH;
					case (abrq_pkg::action_t'(action))
						abrq_pkg::ACT_INSERT: begin
							if (is_end_marker) begin
								kind_d = abrq_pkg::CMD_MARKER;
							end else if (!d_pos) begin
								kind_d = abrq_pkg::CMD_INSERT;
							end else if (too_big) begin
								kind_d = abrq_pkg::CMD_RANGE;
							end else begin
								kind_d  = abrq_pkg::CMD_INSERT;
								state_d = abrq_pkg::F_DIV;
							end
						end
						abrq_pkg::ACT_EOS:   kind_d = abrq_pkg::CMD_EOS;
						abrq_pkg::ACT_POP:   kind_d = abrq_pkg::CMD_POP;
						default:             kind_d = abrq_pkg::CMD_CLEAR;
					endcase
				end
			end
			abrq_pkg::F_DIV: begin
				// restoring divide, one quotient bit per cycle, MSB first
				if (ge) begin
					rem_d = rem_q - shifted[AW-1:0];
				end
				quot_d = {quot_q[RW-2:0], ge};
				k_d    = k_q - SW'(1);
				if (k_q == '0) begin
					state_d = abrq_pkg::F_PUSH;
				end
			end
			abrq_pkg::F_PUSH: begin
				if (kind_q == abrq_pkg::CMD_INSERT && {1'b0, quot_q} >= cfg.n_act) begin
					push_cmd.kind = abrq_pkg::CMD_RANGE;
				end
				if (!fifo_full) begin
					push    = 1'b1;
					state_d = abrq_pkg::F_IDLE;
				end
			end
			default: state_d = abrq_pkg::F_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= abrq_pkg::F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		kind_q <= kind_d;
		rem_q  <= rem_d;
		quot_q <= quot_d;
		k_q    <= k_d;
	end
endmodule
`default_nettype wire

@@ design/abrq_cmd_fifo.sv @@
`default_nettype none
module abrq_cmd_fifo (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire abrq_pkg::cmd_t push_cmd,
	output logic                full,
	input  wire logic           pop,
	output abrq_pkg::cmd_t      pop_cmd,
	output logic                empty
);
	localparam int AW = abrq_pkg::FIFO_AW;
	localparam int CW = abrq_pkg::FIFO_CW;

	abrq_pkg::cmd_t slot_q [abrq_pkg::FIFO_DEPTH];
	logic [AW-1:0]  wr_q, rd_q;
	logic [CW-1:0]  cnt_q;

	assign full    = (cnt_q == CW'(abrq_pkg::FIFO_DEPTH));
	assign empty   = (cnt_q == '0);
	assign pop_cmd = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(abrq_pkg::FIFO_DEPTH - 1)) ? '0 : wr_q + AW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(abrq_pkg::FIFO_DEPTH - 1)) ? '0 : rd_q + AW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_cmd;
		end
	end
endmodule
`default_nettype wire

@@ design/abrq_back.sv @@
`default_nettype none
module abrq_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire abrq_pkg::cfg_t cfg,
	input  wire logic           nrays_wr,
	input  wire logic           fifo_empty,
	input  wire abrq_pkg::cmd_t fifo_cmd,
	output logic                fifo_pop,
	output logic                out_valid,
	input  wire logic           out_ready,
	output abrq_pkg::res_t      out_res
);
	localparam int RW = abrq_pkg::RAY_W;
	localparam int FW = abrq_pkg::FILL_W;
	localparam int CW = abrq_pkg::CNT_W;
	localparam int SW = abrq_pkg::STEP_W;
	localparam int PW = abrq_pkg::CMP_W;
	localparam int NW = CW + RW;

	// ray table and ready ring
	abrq_pkg::ray_ent_t ray_mem [abrq_pkg::MAX_RAYS];
	logic [abrq_pkg::MAX_RAYS-1:0] ray_vld_q;
	abrq_pkg::ray_ent_t ray_rd_q;
	logic               ray_rd_vld_q;
	logic [RW-1:0]      ring_mem [abrq_pkg::MAX_RAYS];
	logic [RW-1:0]      ring_rd_q;

	logic [RW-1:0]      ray_ra, ray_wa, ring_ra, ring_wa, ring_wd;
	logic               ray_we, ring_we;
	abrq_pkg::ray_ent_t ray_wd, ray_cur;

	abrq_pkg::back_state_t state_q, state_d;
	abrq_pkg::cmd_kind_t   kind_q, kind_d;
	logic [RW-1:0]         bin_q, bin_d, idx_q, idx_d, head_q, head_d;
	logic [RW-1:0]         chk_idx_q, chk_idx_d;
	logic [CW-1:0]         total_q, total_d, i_q, i_d;
	logic                  chk_vld_q, chk_vld_d;
	logic [SW-1:0]         k_q, k_d;
	logic                  dirty_q, dirty_d;
	abrq_pkg::res_t        res_q, res_d;
	logic                  out_vld_q;
	abrq_pkg::res_t        out_q;
	logic                  out_load;

	logic [FW-1:0]         new_fill;
	logic [CW-1:0]         pos, head_inc;
	logic [NW-1:0]         n_shift;

	assign ray_cur  = ray_rd_vld_q ? ray_rd_q
		: '{mode: abrq_pkg::MODE_NOT_READY, fill: '0};
	assign pos      = {1'b0, head_q} + total_q;
	assign head_inc = {1'b0, head_q} + CW'(1);
	assign n_shift  = {{RW{1'b0}}, cfg.n_act} << k_q;

	always_comb begin
		abrq_pkg::ray_ent_t ent;
		logic [CW-1:0]      wpos;
		state_d   = state_q;
		kind_d    = kind_q;
		bin_d     = bin_q;
		idx_d     = idx_q;
		head_d    = head_q;
		total_d   = total_q;
		i_d       = i_q;
		chk_vld_d = chk_vld_q;
		chk_idx_d = chk_idx_q;
		k_d       = k_q;
		dirty_d   = dirty_q || nrays_wr;
		res_d     = res_q;
		fifo_pop  = 1'b0;
		out_load  = 1'b0;
		ray_ra    = bin_q;
		ray_we    = 1'b0;
		ray_wa    = bin_q;
		ray_wd    = ray_cur;
		ring_ra   = head_q;
		ring_we   = 1'b0;
		ring_wa   = '0;
		ring_wd   = '0;
		ent       = ray_cur;
		new_fill  = '0;
		wpos      = (pos >= cfg.n_act) ? pos - cfg.n_act : pos;
		case (state_q)
			abrq_pkg::B_IDLE: begin
				if (dirty_q) begin
					k_d     = SW'(RW - 1);
					state_d = abrq_pkg::B_NORM;
				end else if (!fifo_empty) begin
					fifo_pop = 1'b1;
					kind_d   = fifo_cmd.kind;
					bin_d    = fifo_cmd.bin;
					res_d    = '{status: abrq_pkg::ST_OK, ray_index: '0, ray_points: '0,
						ready_count: '0};
					state_d  = abrq_pkg::B_OUT;
					case (fifo_cmd.kind)
						abrq_pkg::CMD_INSERT: begin
							ray_ra  = fifo_cmd.bin;
							state_d = abrq_pkg::B_INS;
						end
						abrq_pkg::CMD_MARKER: res_d.status = abrq_pkg::ST_MARKER;
						abrq_pkg::CMD_RANGE:  res_d.status = abrq_pkg::ST_RANGE;
						abrq_pkg::CMD_EOS: begin
							head_d    = '0;
							total_d   = '0;
							i_d       = '0;
							chk_vld_d = 1'b0;
							state_d   = abrq_pkg::B_EOS;
						end
						abrq_pkg::CMD_POP: begin
							if (total_q == '0) begin
								res_d.status = abrq_pkg::ST_NONE;
							end else begin
								state_d = abrq_pkg::B_TAKE;
							end
						end
						default: begin
							if (total_q != '0) begin
								state_d = abrq_pkg::B_TAKE;
							end
						end
					endcase
				end
			end
			abrq_pkg::B_NORM: begin
				// head mod num_rays after a ring length change
				if ({{CW{1'b0}}, head_q} >= n_shift) begin
					head_d = head_q - n_shift[RW-1:0];
				end
				k_d = k_q - SW'(1);
				if (k_q == '0) begin
					dirty_d = nrays_wr;
					state_d = abrq_pkg::B_IDLE;
				end
			end
			abrq_pkg::B_INS: begin
				if (ent.mode == abrq_pkg::MODE_RESET) begin
					ent = '{mode: abrq_pkg::MODE_NOT_READY, fill: '0};
				end
				res_d.ray_index = bin_q;
				if (ent.fill >= FW'(abrq_pkg::RAY_CAPACITY)) begin
					res_d.status = abrq_pkg::ST_FULL;
				end else begin
					new_fill = ent.fill + FW'(1);
					ent.fill = new_fill;
					if (ent.mode != abrq_pkg::MODE_READY
						&& PW'(cfg.min_pts) <= PW'(new_fill)) begin
						ent.mode = abrq_pkg::MODE_READY;
						if (total_q < cfg.n_act) begin
							ring_we = 1'b1;
							ring_wa = wpos[RW-1:0];
							ring_wd = bin_q;
							total_d = total_q + CW'(1);
						end
					end
				end
				res_d.ray_points = ent.fill;
				ray_we  = 1'b1;
				ray_wd  = ent;
				state_d = abrq_pkg::B_OUT;
			end
			abrq_pkg::B_EOS: begin
				// read one ray per cycle, check it the cycle after
				if (i_q < cfg.n_act) begin
					ray_ra    = i_q[RW-1:0];
					i_d       = i_q + CW'(1);
					chk_vld_d = 1'b1;
					chk_idx_d = i_q[RW-1:0];
				end else begin
					chk_vld_d = 1'b0;
				end
				if (chk_vld_q && ray_cur.mode != abrq_pkg::MODE_RESET && ray_cur.fill != '0) begin
					ring_we = 1'b1;
					ring_wa = total_q[RW-1:0];
					ring_wd = chk_idx_q;
					total_d = total_q + CW'(1);
				end
				if (i_q >= cfg.n_act && !chk_vld_q) begin
					state_d = abrq_pkg::B_OUT;
				end
			end
			abrq_pkg::B_TAKE: begin
				idx_d   = ring_rd_q;
				ray_ra  = ring_rd_q;
				head_d  = (head_inc == cfg.n_act) ? '0 : head_inc[RW-1:0];
				total_d = total_q - CW'(1);
				state_d = abrq_pkg::B_TAKE_WR;
			end
			abrq_pkg::B_TAKE_WR: begin
				ray_we = 1'b1;
				ray_wa = idx_q;
				ray_wd = '{mode: abrq_pkg::MODE_RESET, fill: ray_cur.fill};
				if (kind_q == abrq_pkg::CMD_POP) begin
					res_d.ray_index  = idx_q;
					res_d.ray_points = ray_cur.fill;
					state_d = abrq_pkg::B_OUT;
				end else if (total_q == '0) begin
					state_d = abrq_pkg::B_OUT;
				end else begin
					state_d = abrq_pkg::B_TAKE;
				end
			end
			abrq_pkg::B_OUT: begin
				if (!out_vld_q || out_ready) begin
					out_load = 1'b1;
					state_d  = abrq_pkg::B_IDLE;
				end
			end
			default: state_d = abrq_pkg::B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= abrq_pkg::B_IDLE;
			head_q    <= '0;
			total_q   <= '0;
			dirty_q   <= 1'b0;
			out_vld_q <= 1'b0;
			ray_vld_q <= '0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			total_q <= total_d;
			dirty_q <= dirty_d;
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
			if (ray_we) begin
				ray_vld_q[ray_wa] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		kind_q    <= kind_d;
		bin_q     <= bin_d;
		idx_q     <= idx_d;
		i_q       <= i_d;
		chk_vld_q <= chk_vld_d;
		chk_idx_q <= chk_idx_d;
		k_q       <= k_d;
		res_q     <= res_d;
		if (out_load) begin
			out_q <= '{status: res_q.status, ray_index: res_q.ray_index,
				ray_points: res_q.ray_points, ready_count: total_q};
		end
	end

	always_ff @(posedge clk) begin
		if (ray_we) begin
			ray_mem[ray_wa] <= ray_wd;
		end
		ray_rd_q     <= ray_mem[ray_ra];
		ray_rd_vld_q <= ray_vld_q[ray_ra];
	end

	always_ff @(posedge clk) begin
		if (ring_we) begin
			ring_mem[ring_wa] <= ring_wd;
		end
		ring_rd_q <= ring_mem[ring_ra];
	end

	assign out_valid = out_vld_q;
	assign out_res   = out_q;
endmodule
`default_nettype wire

@@ design/angular_bin_ready_queue.sv @@
`default_nettype none
// Angular bin ready queue. Lidar point azimuths (binary angle units, 65536 per
// turn) are binned into up to 256 rays; each ray counts its points and turns
// ready, and is queued in the ready ring, once it holds the ready threshold. One
// result beat comes back for every input beat, in order: insert reports the
// bin and its count (or marker ignored / ray full / bin out of range), pop
// reports the dequeued ray and marks it reset, end of scan rebuilds the ring
// from every non-empty ray not in reset, reset queue drains the ring.
// s_tuser = {is_end_marker, action}; m_tuser = status. The front end takes one
// beat at a time: an insert that needs a divide waits on its shift-subtract bin
// divider, while markers, inserts with no divide and other actions skip it. A
// two-entry command queue feeds the back end, which works the ray table (one read
// and one write port) one command at a time; end of scan walks all num_rays
// rays, reset queue takes every queued ray in turn, and the first action after
// a num_rays write waits while the ring head is re-folded. Registers (APB, 4-byte
// stride): 0 start angle, 1 ray_width (0 acts as 1), 2 num_rays (0 acts as 1,
// capped at 256), 3 ready threshold, 4 wraps_through_pi. Write them only while
// the block is idle.
module angular_bin_ready_queue (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,  // [15:0] point_angle
	input  wire logic [2:0]  s_tuser,  // [1:0] action, [2] is_end_marker
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,  // [7:0] ray_index, [17:8] ray_points,
	                                   // [26:18] ready_count, [31:27] zero
	output logic [2:0]       m_tuser,  // [2:0] status
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	localparam int CW = abrq_pkg::CNT_W;
	localparam int NW = abrq_pkg::NRAYS_W;
	localparam int MW = abrq_pkg::MINPTS_W;
	localparam int AW = abrq_pkg::ANGLE_W;

	// configuration registers
	logic [AW-1:0] start_ang_q;
	logic [AW-1:0] ray_width_q;
	logic [NW-1:0] num_rays_q;
	logic [MW-1:0] min_pts_q;
	logic          wrap_q;

	logic                cfg_wr;
	logic                nrays_wr;
	abrq_pkg::cfg_reg_t  reg_sel;
	abrq_pkg::cfg_t      cfg;

	logic                push, pop, fifo_full, fifo_empty;
	abrq_pkg::cmd_t      push_cmd, pop_cmd;
	abrq_pkg::res_t      res;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite;
	assign reg_sel  = abrq_pkg::cfg_reg_t'(paddr[4:2]);
	assign nrays_wr = cfg_wr && (reg_sel == abrq_pkg::REG_NUM_RAYS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_ang_q <= 16'h8000;
			ray_width_q <= 16'd256;
			num_rays_q  <= 9'd256;
			min_pts_q   <= 10'd1;
			wrap_q      <= 1'b0;
		end else if (cfg_wr) begin
			case (reg_sel)
				abrq_pkg::REG_START_ANG: start_ang_q <= pwdata[AW-1:0];
				abrq_pkg::REG_RAY_WIDTH: ray_width_q <= pwdata[AW-1:0];
				abrq_pkg::REG_NUM_RAYS:  num_rays_q  <= pwdata[NW-1:0];
				abrq_pkg::REG_MIN_PTS:   min_pts_q   <= pwdata[MW-1:0];
				abrq_pkg::REG_WRAP:      wrap_q      <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			abrq_pkg::REG_START_ANG: prdata = {16'd0, start_ang_q};
			abrq_pkg::REG_RAY_WIDTH: prdata = {16'd0, ray_width_q};
			abrq_pkg::REG_NUM_RAYS:  prdata = {23'd0, num_rays_q};
			abrq_pkg::REG_MIN_PTS:   prdata = {22'd0, min_pts_q};
			abrq_pkg::REG_WRAP:      prdata = {31'd0, wrap_q};
			default:                 prdata = '0;
		endcase
	end

	// ring length in use: zero acts as one, capped at the table size
	always_comb begin
		cfg.start_ang = start_ang_q;
		cfg.ray_width = ray_width_q;
		cfg.min_pts   = min_pts_q;
		cfg.wrap      = wrap_q;
		if (num_rays_q == '0) begin
			cfg.n_act = CW'(1);
		end else if (32'(num_rays_q) > 32'(abrq_pkg::MAX_RAYS)) begin
			cfg.n_act = CW'(abrq_pkg::MAX_RAYS);
		end else begin
			cfg.n_act = CW'(num_rays_q);
		end
	end

	abrq_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.in_valid      (s_tvalid),
		.in_ready      (s_tready),
		.action        (s_tuser[1:0]),
		.point_angle   (s_tdata),
		.is_end_marker (s_tuser[2]),
		.push          (push),
		.push_cmd      (push_cmd),
		.fifo_full     (fifo_full)
	);

	abrq_cmd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (fifo_full),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.empty    (fifo_empty)
	);

	abrq_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.nrays_wr   (nrays_wr),
		.fifo_empty (fifo_empty),
		.fifo_cmd   (pop_cmd),
		.fifo_pop   (pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_res    (res)
	);

	// result beat packing
	assign m_tuser = res.status;
	assign m_tdata = {5'd0, res.ready_count, res.ray_points, res.ray_index};
endmodule
`default_nettype wire

@@ bench/tb_angular_bin_ready_queue.sv @@
`timescale 1ns / 1ps
module tb_angular_bin_ready_queue;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	wire         s_tready;
	logic [15:0] s_tdata = '0;
	logic [2:0]  s_tuser = '0;
	wire         m_tvalid;
	logic        m_tready = 1'b0;
	wire [31:0]  m_tdata;
	wire [2:0]   m_tuser;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	wire [31:0]  prdata;
	wire         pready;

	angular_bin_ready_queue u_top (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// predictor state: registers and ray table
	logic signed [15:0]  p_start_ang;
	logic [15:0]         p_ray_width;
	logic [8:0]          p_num_rays;
	logic [9:0]          p_min_pts;
	logic                p_wrap;
	abrq_pkg::ray_mode_t p_mode [abrq_pkg::MAX_RAYS];
	int unsigned         p_fill [abrq_pkg::MAX_RAYS];
	int unsigned         p_ring [abrq_pkg::MAX_RAYS];
	int unsigned         p_head, p_total;

	abrq_pkg::res_t exp_results [$];
	int     n_fail = 0;
	int     cycles = 0;
	int     rx_gap = 0;
	logic   no_idle = 1'b0;   // last part of the run: no bubbles
	logic   rx_on = 1'b0;

	task automatic predictor_reset();
		p_start_ang = -16'sd32768; p_ray_width = 16'd256; p_num_rays = 9'd256;
		p_min_pts = 10'd1; p_wrap = 1'b0;
		for (int i = 0; i < abrq_pkg::MAX_RAYS; i++) begin
			p_mode[i] = abrq_pkg::MODE_NOT_READY; p_fill[i] = 0; p_ring[i] = 0;
		end
		p_head = 0; p_total = 0;
	endtask

	function automatic int unsigned rays_in_use();
		if (p_num_rays == 0) return 1;
		if (p_num_rays > abrq_pkg::MAX_RAYS) return abrq_pkg::MAX_RAYS;
		return p_num_rays;
	endfunction

	function automatic int unsigned dequeue_ray(int unsigned n);
		int unsigned h, idx;
		h = p_head % n;
		idx = p_ring[h] % abrq_pkg::MAX_RAYS;
		p_head = (h + 1) % n;
		p_total--;
		p_mode[idx] = abrq_pkg::MODE_RESET;
		return idx;
	endfunction

	function automatic abrq_pkg::res_t predict_beat(abrq_pkg::action_t act,
		logic signed [15:0] ang, logic marker);
		abrq_pkg::res_t r;
		int n, d, w, bin;
		int unsigned dummy;
		n = rays_in_use();
		r = '0;
		r.status = abrq_pkg::ST_OK;
		case (act)
			abrq_pkg::ACT_INSERT: begin
				if (marker) r.status = abrq_pkg::ST_MARKER;
				else begin
					d = int'(ang) - int'(p_start_ang);
					w = (p_ray_width == 0) ? 1 : int'(p_ray_width);
					if (p_wrap && d < 0) d += 65536;
					bin = (d > 0) ? d / w : 0;
					if (bin >= n) r.status = abrq_pkg::ST_RANGE;
					else begin
						if (p_mode[bin] == abrq_pkg::MODE_RESET) begin
							p_fill[bin] = 0; p_mode[bin] = abrq_pkg::MODE_NOT_READY;
						end
						if (p_fill[bin] >= abrq_pkg::RAY_CAPACITY) r.status = abrq_pkg::ST_FULL;
						else begin
							p_fill[bin]++;
							if (p_mode[bin] != abrq_pkg::MODE_READY
								&& p_min_pts <= p_fill[bin]) begin
								p_mode[bin] = abrq_pkg::MODE_READY;
								if (p_total < n) begin
									p_ring[(p_head + p_total) % n] = bin;
									p_total++;
								end
							end
						end
						r.ray_index = bin[7:0];
						r.ray_points = p_fill[bin][9:0];
					end
				end
			end
			abrq_pkg::ACT_EOS: begin
				p_head = 0; p_total = 0;
				for (int i = 0; i < n; i++)
					if (p_mode[i] != abrq_pkg::MODE_RESET && p_fill[i] != 0) begin
						p_ring[p_total] = i; p_total++;
					end
			end
			abrq_pkg::ACT_POP: begin
				if (p_total == 0) r.status = abrq_pkg::ST_NONE;
				else begin
					bin = dequeue_ray(n);
					r.ray_index = bin[7:0];
					r.ray_points = p_fill[bin][9:0];
				end
			end
			default: while (p_total != 0) dummy = dequeue_ray(n);
		endcase
		r.ready_count = p_total[8:0];
		return r;
	endfunction

	// random bubbles on the receive side
	always @(posedge clk) begin
		if (!rx_on || no_idle) begin
			m_tready <= rx_on;
			rx_gap <= 0;
		end else if (rx_gap != 0) begin
			rx_gap <= rx_gap - 1;
			if (rx_gap == 1) m_tready <= 1'b1;
		end else if ($urandom_range(0, 5) == 0) begin
			m_tready <= 1'b0;
			rx_gap <= $urandom_range(1, 3);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// result checker: compare every accepted beat with the oldest expectation
	always @(posedge clk) begin
		abrq_pkg::res_t e;
		cycles <= cycles + 1;
		if (m_tvalid && m_tready) begin
			if (exp_results.size() == 0) begin
				$error("result beat with nothing expected");
				n_fail++;
			end else begin
				e = exp_results.pop_front();
				if (m_tuser !== e.status) begin
					$error("status exp %0d got %0d", e.status, m_tuser); n_fail++;
				end
				if (m_tdata[7:0] !== e.ray_index) begin
					$error("ray_index exp %0d got %0d", e.ray_index, m_tdata[7:0]); n_fail++;
				end
				if (m_tdata[17:8] !== e.ray_points) begin
					$error("ray_points exp %0d got %0d", e.ray_points, m_tdata[17:8]);
					n_fail++;
				end
				if (m_tdata[26:18] !== e.ready_count) begin
					$error("ready_count exp %0d got %0d", e.ready_count, m_tdata[26:18]);
					n_fail++;
				end
				if (m_tdata[31:27] !== 5'd0) begin
					$error("pad exp 0 got %0d", m_tdata[31:27]); n_fail++;
				end
			end
		end
	end

	// overall limit
	always @(posedge clk)
		if (cycles > 2000000) begin
			$display("CHECKS FAILED");
			$finish;
		end

	task automatic reg_write(abrq_pkg::cfg_reg_t idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {idx, 2'b00}; pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (idx)
			abrq_pkg::REG_START_ANG: p_start_ang = val[15:0];
			abrq_pkg::REG_RAY_WIDTH: p_ray_width = val[15:0];
			abrq_pkg::REG_NUM_RAYS:  p_num_rays = val[8:0];
			abrq_pkg::REG_MIN_PTS:   p_min_pts = val[9:0];
			default:                 p_wrap = val[0];
		endcase
	endtask

	// wait for all results, then let the back end settle (end of scan is long)
	task automatic drain();
		while (exp_results.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	// one beat; with chk set the expected result is the typed-in one
	task automatic send_beat(abrq_pkg::action_t act, logic [15:0] ang, logic marker,
		logic chk = 1'b0, abrq_pkg::res_t fixed = '0);
		abrq_pkg::res_t r;
		if (!no_idle && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		r = predict_beat(act, ang, marker);
		if (chk && r !== fixed) begin
			$error("table row disagrees: exp %h pred %h", fixed, r);
			n_fail++;
		end
		exp_results.insert(exp_results.size(), chk ? fixed : r);
		s_tvalid <= 1'b1; s_tdata <= ang; s_tuser <= {marker, act};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// empty the ready ring before the ring length changes
	task automatic flush_queue();
		send_beat(abrq_pkg::ACT_CLEAR, 16'h0, 1'b0);
		s_tvalid <= 1'b0;
		drain();
	endtask

	function automatic abrq_pkg::res_t mk(abrq_pkg::status_t st, int idx, int pts, int cnt);
		abrq_pkg::res_t r;
		r.status = st; r.ray_index = 8'(idx); r.ray_points = 10'(pts);
		r.ready_count = 9'(cnt);
		return r;
	endfunction

	typedef struct {
		abrq_pkg::action_t act;
		logic [15:0]       ang;
		logic              marker;
		logic              chk;
		abrq_pkg::res_t    res;
	} row_t;

	// pick an angle that falls on a ray in use most of the time
	function automatic logic [15:0] pick_angle();
		int n, w, b;
		if ($urandom_range(0, 9) == 0) return 16'($urandom());
		n = rays_in_use();
		w = (p_ray_width == 0) ? 1 : p_ray_width;
		b = $urandom_range(0, n - 1);
		return 16'(int'(p_start_ang) + b * w + $urandom_range(0, w - 1));
	endfunction

	task automatic random_phase(int items);
		abrq_pkg::action_t a;
		int k;
		for (int i = 0; i < items; i++) begin
			k = $urandom_range(0, 99);
			if (k < 70) a = abrq_pkg::ACT_INSERT;
			else if (k < 80) a = abrq_pkg::ACT_EOS;
			else if (k < 96) a = abrq_pkg::ACT_POP;
			else a = abrq_pkg::ACT_CLEAR;
			send_beat(a, pick_angle(), ($urandom_range(0, 19) == 0));
		end
		s_tvalid <= 1'b0;
	endtask

	row_t dir_rows [$];

	initial begin
		predictor_reset();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		rx_on <= 1'b1;
		@(posedge clk);

		// directed table, reset settings: ray = angle[15:8] + 128
		dir_rows = '{
			'{abrq_pkg::ACT_POP,    16'h0000, 1'b0, 1'b1, mk(abrq_pkg::ST_NONE, 0, 0, 0)},
			'{abrq_pkg::ACT_INSERT, 16'h8000, 1'b0, 1'b1, mk(abrq_pkg::ST_OK, 0, 1, 1)},
			'{abrq_pkg::ACT_INSERT, 16'h7FFF, 1'b0, 1'b1, mk(abrq_pkg::ST_OK, 255, 1, 2)},
			'{abrq_pkg::ACT_INSERT, 16'h1234, 1'b1, 1'b1, mk(abrq_pkg::ST_MARKER, 0, 0, 2)},
			'{abrq_pkg::ACT_INSERT, 16'h8000, 1'b0, 1'b1, mk(abrq_pkg::ST_OK, 0, 2, 2)},
			'{abrq_pkg::ACT_POP,    16'h0000, 1'b0, 1'b1, mk(abrq_pkg::ST_OK, 0, 2, 1)},
			'{abrq_pkg::ACT_INSERT, 16'h8001, 1'b0, 1'b1, mk(abrq_pkg::ST_OK, 0, 1, 2)},
			'{abrq_pkg::ACT_EOS,    16'h0000, 1'b0, 1'b1, mk(abrq_pkg::ST_OK, 0, 0, 2)},
			'{abrq_pkg::ACT_CLEAR,  16'h0000, 1'b0, 1'b1, mk(abrq_pkg::ST_OK, 0, 0, 0)},
			'{abrq_pkg::ACT_EOS,    16'h0000, 1'b0, 1'b1, mk(abrq_pkg::ST_OK, 0, 0, 0)},
			'{abrq_pkg::ACT_INSERT, 16'h0000, 1'b0, 1'b0, '0},
			'{abrq_pkg::ACT_POP,    16'h0000, 1'b1, 1'b0, '0}
		};
		foreach (dir_rows[i])
			send_beat(dir_rows[i].act, dir_rows[i].ang, dir_rows[i].marker,
				dir_rows[i].chk, dir_rows[i].res);
		s_tvalid <= 1'b0;
		drain();

		// few rays, threshold 0: range errors and rays ready on their first point
		reg_write(abrq_pkg::REG_NUM_RAYS, 32'd4);
		reg_write(abrq_pkg::REG_RAY_WIDTH, 32'd0);
		reg_write(abrq_pkg::REG_START_ANG, 32'h0000_0000);
		reg_write(abrq_pkg::REG_MIN_PTS, 32'd0);
		send_beat(abrq_pkg::ACT_INSERT, 16'hFFFF, 1'b0);   // negative offset: bin 0
		send_beat(abrq_pkg::ACT_INSERT, 16'h0004, 1'b0, 1'b1,
			mk(abrq_pkg::ST_RANGE, 0, 0, 1));
		send_beat(abrq_pkg::ACT_INSERT, 16'h0003, 1'b0);
		s_tvalid <= 1'b0;
		drain();

		// single ray filled to capacity
		reg_write(abrq_pkg::REG_NUM_RAYS, 32'd1);
		reg_write(abrq_pkg::REG_RAY_WIDTH, 32'hFFFF);
		reg_write(abrq_pkg::REG_MIN_PTS, 32'd512);
		reg_write(abrq_pkg::REG_WRAP, 32'd1);
		reg_write(abrq_pkg::REG_START_ANG, 32'h0000_8000);
		for (int i = 0; i < 515; i++) send_beat(abrq_pkg::ACT_INSERT, 16'($urandom()), 1'b0);
		send_beat(abrq_pkg::ACT_POP, 16'h0, 1'b0);
		s_tvalid <= 1'b0;
		drain();

		// wrapping field, small ring that overflows
		flush_queue();
		reg_write(abrq_pkg::REG_NUM_RAYS, 32'd8);
		reg_write(abrq_pkg::REG_RAY_WIDTH, 32'd2000);
		reg_write(abrq_pkg::REG_START_ANG, 32'h0000_6000);
		reg_write(abrq_pkg::REG_MIN_PTS, 32'd2);
		random_phase(300);
		drain();

		// num_rays above the maximum, wrap off, negative start
		flush_queue();
		reg_write(abrq_pkg::REG_NUM_RAYS, 32'h1FF);
		reg_write(abrq_pkg::REG_WRAP, 32'd0);
		reg_write(abrq_pkg::REG_RAY_WIDTH, 32'd300);
		reg_write(abrq_pkg::REG_START_ANG, 32'h0000_C000);
		reg_write(abrq_pkg::REG_MIN_PTS, 32'd3);
		random_phase(250);
		drain();

		// midrange setting, threshold 1
		flush_queue();
		reg_write(abrq_pkg::REG_NUM_RAYS, 32'd32);
		reg_write(abrq_pkg::REG_RAY_WIDTH, 32'd1);
		reg_write(abrq_pkg::REG_START_ANG, 32'h0000_7FF0);
		reg_write(abrq_pkg::REG_MIN_PTS, 32'd1);
		reg_write(abrq_pkg::REG_WRAP, 32'd1);
		random_phase(250);
		drain();

		// back at reset values, final part with no bubbles at all
		flush_queue();
		reg_write(abrq_pkg::REG_NUM_RAYS, 32'd256);
		reg_write(abrq_pkg::REG_RAY_WIDTH, 32'd256);
		reg_write(abrq_pkg::REG_START_ANG, 32'h0000_8000);
		reg_write(abrq_pkg::REG_MIN_PTS, 32'd1);
		reg_write(abrq_pkg::REG_WRAP, 32'd0);
		random_phase(150);
		no_idle = 1'b1;
		random_phase(150);
		drain();

		if (n_fail == 0) $display("ALL CHECKS PASSED");
		else $display("CHECKS FAILED");
		$finish;
	end

endmodule
